// File: src/tsci_pkg.sv
// Shared types and constants for the text screen control interpreter.
`timescale 1ns / 1ps
`default_nettype none

package tsci_pkg;

    localparam logic [1:0] OP_FEED = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_NEW  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_MODIFY,
        S_HOLD
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUT,
        ACT_ERASE,
        ACT_READ
    } t_act;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_CARET,
        PH_ROW
    } t_phase;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_mem_ctl;

endpackage

`default_nettype wire

// File: src/text_screen_control_interpreter_core.sv
// Top level of the text screen control interpreter: decoder, cursor and row update.
//
// Input channel (s): tuser carries the opcode (feed byte, read cell, new case),
// tdata carries the stream byte and the cell address to read.
// Output channel (m): one item per read-cell opcode with the character at the
// cell, the cursor position and the insert flag.
// The screen is a memory of one row per word. Every item is taken in the idle
// state and decoded in the next cycle; a write or erase reads the cursor row
// and writes it back in the modify state, a read selects its cell there.
// Items that touch no row return to idle after decode; row updates and reads
// also pass the modify state, as the row memory read is registered.
// Results sit in an output register, so the next item is accepted while a
// result waits; a read that finds the output register still full waits
// until the receiver takes it.
// Reset (synchronous, active low) and the new-case opcode clear the screen
// through per-row valid bits, home the cursor and select overwrite mode.
`timescale 1ns / 1ps
`default_nettype none

module text_screen_control_interpreter_core #(
    parameter int SCREEN_SIZE = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // in_byte[7:0], read_row[11:8], read_col[15:12]
    input  wire  [1:0]  i_s_tuser,   // opcode[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata    // cell_char[7:0], cursor_row[11:8], cursor_col[15:12],
                                     // insert_on[16], zero[23:17]
);

    localparam int             CW      = $clog2(SCREEN_SIZE);
    localparam int             DW      = SCREEN_SIZE * 8;
    localparam logic [CW-1:0]  L_LAST  = CW'(SCREEN_SIZE - 1);
    localparam logic [3:0]     L_LAST4 = 4'(SCREEN_SIZE - 1);
    localparam logic [4:0]     L_N5    = 5'(SCREEN_SIZE);

    tsci_pkg::t_state  r_state, n_state;
    tsci_pkg::t_act    r_act, n_act;
    tsci_pkg::t_phase  r_phase, n_phase;
    logic [1:0]        r_op;
    logic [7:0]        r_byte;
    logic [3:0]        r_rrow, r_rcol;
    logic [CW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [CW-1:0]     r_pend, n_pend;
    logic              r_ins, n_ins;
    logic              r_in_range, n_in_range;
    logic [7:0]        r_cell, n_cell;
    logic              r_out_valid, n_out_valid;
    logic [23:0]       r_out_data, n_out_data;

    tsci_pkg::t_mem_ctl                w_ctl;
    logic [CW-1:0]                     w_rd_addr;
    logic [DW-1:0]                     w_rd_data;
    logic [SCREEN_SIZE-1:0][7:0]       w_old;
    logic [SCREEN_SIZE-1:0][7:0]       w_new;
    logic [7:0]                        w_cell;

    function automatic logic [CW-1:0] f_digit(input logic [7:0] b);
        logic [3:0] v;
        v = b[3:0];
        return (v > L_LAST4) ? L_LAST : CW'(v);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] b);
        return b inside {[tsci_pkg::CH_0:tsci_pkg::CH_9]};
    endfunction

    tsci_row_mem #(
        .SCREEN_SIZE (SCREEN_SIZE)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (r_row),
        .i_wr_data (w_new),
        .o_rd_data (w_rd_data)
    );

    assign w_old = w_rd_data;

    // row update: insert shift, cell write or erase to end of row
    always_comb begin
        w_new = w_old;
        if (r_act == tsci_pkg::ACT_ERASE) begin
            for (int j = 0; j < SCREEN_SIZE; j++) begin
                if (CW'(j) >= r_col) begin
                    w_new[j] = tsci_pkg::CH_SP;
                end
            end
        end else begin
            for (int j = 1; j < SCREEN_SIZE; j++) begin
                if (r_ins && (CW'(j) > r_col)) begin
                    w_new[j] = w_old[j-1];
                end
            end
            w_new[r_col] = r_byte;
        end
    end

    assign w_cell = r_in_range ? w_old[r_rcol[CW-1:0]] : tsci_pkg::CH_SP;

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_phase     = r_phase;
        n_row       = r_row;
        n_col       = r_col;
        n_pend      = r_pend;
        n_ins       = r_ins;
        n_in_range  = r_in_range;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        w_ctl       = '0;
        w_rd_addr   = r_row;
        o_s_tready  = 1'b0;
        case (r_state)
            tsci_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = tsci_pkg::S_DECODE;
                end
            end
            tsci_pkg::S_DECODE: begin
                n_state = tsci_pkg::S_IDLE;
                n_act   = tsci_pkg::ACT_NONE;
                case (r_op)
                    tsci_pkg::OP_FEED: begin
                        if (r_byte == tsci_pkg::CH_LF) begin
                            n_phase = tsci_pkg::PH_NORMAL;
                        end else begin
                            case (r_phase)
                                tsci_pkg::PH_NORMAL: begin
                                    if (r_byte == tsci_pkg::CH_CARET) begin
                                        n_phase = tsci_pkg::PH_CARET;
                                    end else begin
                                        n_act = tsci_pkg::ACT_PUT;
                                    end
                                end
                                tsci_pkg::PH_CARET: begin
                                    n_phase = tsci_pkg::PH_NORMAL;
                                    case (r_byte)
                                        tsci_pkg::CH_B: n_col = '0;
                                        tsci_pkg::CH_C: w_ctl.clr = 1'b1;
                                        tsci_pkg::CH_D: begin
                                            if (r_row != L_LAST) n_row = r_row + 1'b1;
                                        end
                                        tsci_pkg::CH_E: n_act = tsci_pkg::ACT_ERASE;
                                        tsci_pkg::CH_H: begin
                                            n_row = '0;
                                            n_col = '0;
                                        end
                                        tsci_pkg::CH_I: n_ins = 1'b1;
                                        tsci_pkg::CH_L: begin
                                            if (r_col != '0) n_col = r_col - 1'b1;
                                        end
                                        tsci_pkg::CH_O: n_ins = 1'b0;
                                        tsci_pkg::CH_R: begin
                                            if (r_col != L_LAST) n_col = r_col + 1'b1;
                                        end
                                        tsci_pkg::CH_U: begin
                                            if (r_row != '0) n_row = r_row - 1'b1;
                                        end
                                        tsci_pkg::CH_CARET: n_act = tsci_pkg::ACT_PUT;
                                        default: begin
                                            if (f_is_digit(r_byte)) begin
                                                n_pend  = f_digit(r_byte);
                                                n_phase = tsci_pkg::PH_ROW;
                                            end
                                        end
                                    endcase
                                end
                                default: begin
                                    n_phase = tsci_pkg::PH_NORMAL;
                                    if (f_is_digit(r_byte)) begin
                                        n_row = r_pend;
                                        n_col = f_digit(r_byte);
                                    end
                                end
                            endcase
                        end
                    end
                    tsci_pkg::OP_READ: begin
                        n_act      = tsci_pkg::ACT_READ;
                        n_in_range = ({1'b0, r_rrow} < L_N5) && ({1'b0, r_rcol} < L_N5);
                        w_rd_addr  = r_rrow[CW-1:0];
                    end
                    tsci_pkg::OP_NEW: begin
                        w_ctl.clr = 1'b1;
                        n_row     = '0;
                        n_col     = '0;
                        n_ins     = 1'b0;
                        n_phase   = tsci_pkg::PH_NORMAL;
                        n_pend    = '0;
                    end
                    default: ;
                endcase
                if (n_act != tsci_pkg::ACT_NONE) begin
                    w_ctl.rd_en = 1'b1;
                    n_state     = tsci_pkg::S_MODIFY;
                end
            end
            tsci_pkg::S_MODIFY: begin
                n_state = tsci_pkg::S_IDLE;
                case (r_act)
                    tsci_pkg::ACT_PUT: begin
                        w_ctl.wr_en = 1'b1;
                        if (r_col != L_LAST) n_col = r_col + 1'b1;
                    end
                    tsci_pkg::ACT_ERASE: w_ctl.wr_en = 1'b1;
                    tsci_pkg::ACT_READ: begin
                        if (!r_out_valid || i_m_tready) begin
                            n_out_valid = 1'b1;
                            n_out_data  = {7'b0, r_ins, 4'(r_col), 4'(r_row), w_cell};
                        end else begin
                            n_cell  = w_cell;
                            n_state = tsci_pkg::S_HOLD;
                        end
                    end
                    default: ;
                endcase
            end
            tsci_pkg::S_HOLD: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'b0, r_ins, 4'(r_col), 4'(r_row), r_cell};
                    n_state     = tsci_pkg::S_IDLE;
                end
            end
            default: n_state = tsci_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsci_pkg::S_IDLE;
            r_phase     <= tsci_pkg::PH_NORMAL;
            r_row       <= '0;
            r_col       <= '0;
            r_pend      <= '0;
            r_ins       <= 1'b0;
            r_out_valid <= 1'b0;
            r_act       <= tsci_pkg::ACT_NONE;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pend      <= n_pend;
            r_ins       <= n_ins;
            r_out_valid <= n_out_valid;
            r_act       <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op   <= i_s_tuser;
            r_byte <= i_s_tdata[7:0];
            r_rrow <= i_s_tdata[11:8];
            r_rcol <= i_s_tdata[15:12];
        end
        r_in_range <= n_in_range;
        r_cell     <= n_cell;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= L_LAST) && (r_col <= L_LAST))
        else $error("cursor outside the screen");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == tsci_pkg::S_DECODE))
        else $error("accepted item not decoded");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsci_pkg::S_HOLD) |-> r_out_valid)
        else $error("read result held while output register free");

endmodule

`default_nettype wire

// File: src/tsci_row_mem.sv
// Row-wide screen memory with per-row valid bits; invalid rows read as spaces.
`timescale 1ns / 1ps
`default_nettype none

module tsci_row_mem #(
    parameter int SCREEN_SIZE = 10
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  tsci_pkg::t_mem_ctl              i_ctl,
    input  wire  [$clog2(SCREEN_SIZE)-1:0]  i_rd_addr,
    input  wire  [$clog2(SCREEN_SIZE)-1:0]  i_wr_addr,
    input  wire  [SCREEN_SIZE*8-1:0]        i_wr_data,
    output logic [SCREEN_SIZE*8-1:0]        o_rd_data
);

    localparam int DW = SCREEN_SIZE * 8;

    logic [DW-1:0]          r_mem [SCREEN_SIZE];
    logic [SCREEN_SIZE-1:0] r_valid;
    logic [DW-1:0]          r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : {SCREEN_SIZE{tsci_pkg::CH_SP}};

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the text screen control interpreter core.
`timescale 1ns / 1ps

module testbench;
    import tsci_pkg::*;

    localparam int          SZ          = 10;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [7:0]  CH_UNKNOWN  = 8'h71;
    localparam logic [7:0]  CH_NONDIGIT = 8'h6B;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          HOLD_CYCLES = 80;
    localparam int          N_ITEMS     = 1700;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] row;
        logic [3:0] col;
        logic       ins;
    } t_cell_view;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [3:0] rd_row;
        logic [3:0] rd_col;
        logic       typed;
        t_cell_view want;
    } t_dir_row;

    localparam t_cell_view BLANK_HOME = '{CH_SP, 4'd0, 4'd0, 1'b0};
    localparam t_cell_view NO_WANT    = '0;
    localparam int         N_DIR      = 30;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // screen model state
    logic [7:0] scr [0:SZ*SZ-1];
    int         cur_row;
    int         cur_col;
    logic       ins_mode;
    t_phase     seq_phase;
    int         pend_row;

    t_cell_view cells_due [$];
    t_dir_row   dir_tab [0:N_DIR-1];

    int  n_mismatch = 0;
    int  n_items    = 0;
    int  n_reads    = 0;
    int  n_checked  = 0;
    int  n_cmds     = 0;
    int  n_addr     = 0;
    int  n_holds    = 0;
    int  burst_left = 0;
    int  idle_cnt   = 0;
    bit  hold_req   = 0;

    text_screen_control_interpreter_core #(
        .SCREEN_SIZE(SZ)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic int digit_to_pos(input logic [7:0] b);
        int v;
        v = int'(b) - int'(CH_0);
        return (v > SZ - 1) ? SZ - 1 : v;
    endfunction

    function automatic bit is_command(input logic [7:0] b);
        case (b)
            CH_B, CH_C, CH_D, CH_E, CH_H, CH_I, CH_L, CH_O, CH_R, CH_U, CH_CARET, CH_LF:
                return 1'b1;
            default:
                return is_digit(b);
        endcase
    endfunction

    task automatic screen_clear();
        for (int k = 0; k < SZ * SZ; k++) scr[k] = CH_SP;
    endtask

    task automatic screen_home_all();
        screen_clear();
        cur_row   = 0;
        cur_col   = 0;
        ins_mode  = 1'b0;
        seq_phase = PH_NORMAL;
        pend_row  = 0;
    endtask

    task automatic screen_put(input logic [7:0] c);
        int base;
        base = cur_row * SZ;
        if (ins_mode) begin
            for (int j = SZ - 1; j > cur_col; j--) scr[base + j] = scr[base + j - 1];
        end
        scr[base + cur_col] = c;
        if (cur_col < SZ - 1) cur_col++;
    endtask

    task automatic screen_command(input logic [7:0] c);
        case (c)
            CH_B:     cur_col = 0;
            CH_C:     screen_clear();
            CH_D:     if (cur_row < SZ - 1) cur_row++;
            CH_E: begin
                for (int j = cur_col; j < SZ; j++) scr[cur_row * SZ + j] = CH_SP;
            end
            CH_H: begin
                cur_row = 0;
                cur_col = 0;
            end
            CH_I:     ins_mode = 1'b1;
            CH_L:     if (cur_col > 0) cur_col--;
            CH_O:     ins_mode = 1'b0;
            CH_R:     if (cur_col < SZ - 1) cur_col++;
            CH_U:     if (cur_row > 0) cur_row--;
            CH_CARET: screen_put(c);
            default: begin
                if (is_digit(c)) begin
                    pend_row  = digit_to_pos(c);
                    seq_phase = PH_ROW;
                end
            end
        endcase
    endtask

    task automatic screen_feed(input logic [7:0] b);
        if (b == CH_LF) begin
            seq_phase = PH_NORMAL;
        end else begin
            case (seq_phase)
                PH_NORMAL: begin
                    if (b == CH_CARET) seq_phase = PH_CARET;
                    else screen_put(b);
                end
                PH_CARET: begin
                    seq_phase = PH_NORMAL;
                    screen_command(b);
                end
                default: begin
                    seq_phase = PH_NORMAL;
                    if (is_digit(b)) begin
                        cur_row = pend_row;
                        cur_col = digit_to_pos(b);
                    end
                end
            endcase
        end
    endtask

    // apply one accepted item; returns 1 with the cell view for a read
    task automatic screen_step(input logic [1:0] op, input logic [7:0] b,
                               input logic [3:0] rr, input logic [3:0] rc,
                               output bit has_res, output t_cell_view res);
        has_res = 1'b0;
        res     = '0;
        case (op)
            OP_FEED: screen_feed(b);
            OP_READ: begin
                has_res = 1'b1;
                res.ch  = (rr < SZ && rc < SZ) ? scr[rr * SZ + rc] : CH_SP;
                res.row = cur_row[3:0];
                res.col = cur_col[3:0];
                res.ins = ins_mode;
            end
            OP_NEW:  screen_home_all();
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        n_mismatch++;
        if (n_mismatch <= 30)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                             input logic [3:0] rr, input logic [3:0] rc,
                             input bit typed, input t_cell_view want);
        int         gap;
        bit         has_res;
        t_cell_view res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rc, rr, b};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        screen_step(op, b, rr, rc, has_res, res);
        if (has_res) begin
            cells_due.push_back(typed ? want : res);
            n_reads++;
        end
        if (op != OP_UNUSED) n_items++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic feed(input logic [7:0] b);
        send_item(OP_FEED, b, 4'($urandom), 4'($urandom), 1'b0, NO_WANT);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (cells_due.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [3:0] rand_addr();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, SZ - 1));
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_LF || b == CH_CARET);
        return b;
    endfunction

    task automatic random_sequence();
        int         kind;
        logic [7:0] b;
        logic [7:0] cmds [0:10];
        cmds = '{CH_B, CH_C, CH_D, CH_E, CH_H, CH_I, CH_L, CH_O, CH_R, CH_U, CH_CARET};
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            feed(rand_plain());
        end else if (kind < 52) begin
            b = cmds[$urandom_range(0, 10)];
            if (b == CH_C && $urandom_range(0, 3) != 0) b = CH_E;
            feed(CH_CARET);
            feed(b);
            n_cmds++;
        end else if (kind < 62) begin
            feed(CH_CARET);
            feed(CH_0 + 8'($urandom_range(0, 9)));
            feed(CH_0 + 8'($urandom_range(0, 9)));
            n_addr++;
        end else if (kind < 88) begin
            send_item(OP_READ, 8'($urandom), rand_addr(), rand_addr(), 1'b0, NO_WANT);
        end else if (kind < 94) begin
            feed(CH_CARET);
            case ($urandom_range(0, 3))
                0: begin
                    do b = 8'($urandom); while (is_command(b));
                    feed(b);
                end
                1: begin
                    feed(CH_0 + 8'($urandom_range(0, 9)));
                    do b = 8'($urandom); while (is_digit(b) || b == CH_LF);
                    feed(b);
                end
                2: feed(CH_LF);
                default: begin
                    feed(CH_0 + 8'($urandom_range(0, 9)));
                    feed(CH_LF);
                end
            endcase
        end else if (kind < 98) begin
            if ($urandom_range(0, 1) == 0)
                send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom), 1'b0, NO_WANT);
            else
                feed(CH_LF);
        end else begin
            send_item(OP_NEW, 8'($urandom), 4'($urandom), 4'($urandom), 1'b0, NO_WANT);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        t_cell_view want;
        if (rst_n && m_tvalid && m_tready) begin
            if (cells_due.size() == 0) begin
                report_mismatch("result with none pending", int'(m_tdata), 0);
            end else begin
                want = cells_due.pop_front();
                n_checked++;
                if (m_tdata[7:0] !== want.ch)
                    report_mismatch("cell_char", int'(m_tdata[7:0]), int'(want.ch));
                if (m_tdata[11:8] !== want.row)
                    report_mismatch("cursor_row", int'(m_tdata[11:8]), int'(want.row));
                if (m_tdata[15:12] !== want.col)
                    report_mismatch("cursor_col", int'(m_tdata[15:12]), int'(want.col));
                if (m_tdata[16] !== want.ins)
                    report_mismatch("insert_on", int'(m_tdata[16]), int'(want.ins));
                if (m_tdata[23:17] !== 7'd0)
                    report_mismatch("pad bits", int'(m_tdata[23:17]), 0);
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        int mode;
        int left;
        int tick;
        m_tready = 1'b0;
        mode     = 0;
        left     = 0;
        tick     = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                n_holds++;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(32, 128);
                end
                left--;
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    2:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("text_screen_control_interpreter_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int next_hold;
        int next_drain;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_FEED;
        rst_n    = 1'b0;
        screen_home_all();

        dir_tab = '{
            '{OP_READ,   8'h00,       4'd0,  4'd0,  1'b1, BLANK_HOME},
            '{OP_READ,   8'hFF,       4'd15, 4'd15, 1'b1, BLANK_HOME},
            '{OP_READ,   8'h00,       4'd3,  4'd10, 1'b1, BLANK_HOME},
            '{OP_FEED,   8'hFF,       4'd15, 4'd15, 1'b0, NO_WANT},
            '{OP_FEED,   8'h00,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   8'h41,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_I,        4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   8'h5A,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_READ,   8'h00,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_9,        4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_9,        4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   8'h51,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_READ,   8'h00,       4'd9,  4'd9,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_UNKNOWN,  4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_0 + 8'd3, 4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_NONDIGIT, 4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_CARET,    4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_LF,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_FEED,   CH_0 + 8'd7, 4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_UNUSED, 8'hFF,       4'd15, 4'd15, 1'b0, NO_WANT},
            '{OP_READ,   8'h00,       4'd9,  4'd0,  1'b0, NO_WANT},
            '{OP_NEW,    8'h00,       4'd0,  4'd0,  1'b0, NO_WANT},
            '{OP_READ,   8'h00,       4'd0,  4'd0,  1'b1, BLANK_HOME},
            '{OP_READ,   8'h00,       4'd9,  4'd9,  1'b1, BLANK_HOME}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < N_DIR; k++)
            send_item(dir_tab[k].op, dir_tab[k].data, dir_tab[k].rd_row,
                      dir_tab[k].rd_col, dir_tab[k].typed, dir_tab[k].want);
        wait_drained();

        next_hold  = 300;
        next_drain = 500;
        while (n_items < N_ITEMS) begin
            if (n_items >= next_hold) begin
                // long receiver hold-off while reads keep coming
                hold_req   = 1'b1;
                burst_left = 12;
                repeat (8) send_item(OP_READ, 8'($urandom), rand_addr(), rand_addr(),
                                     1'b0, NO_WANT);
                next_hold += 600;
            end
            if (n_items >= next_drain) begin
                wait_drained();
                next_drain += 500;
            end
            random_sequence();
        end

        s_tvalid <= 1'b0;
        while (cells_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run: %0d items, %0d reads (%0d checked), %0d caret commands, %0d addressings",
                 n_items, n_reads, n_checked, n_cmds, n_addr);
        $display("run: %0d long receiver hold-offs, %0d mismatches", n_holds, n_mismatch);
        if (n_mismatch == 0 && cells_due.size() == 0) begin
            $display("text_screen_control_interpreter_core: match");
        end else begin
            $display("text_screen_control_interpreter_core: mismatch");
        end
        $finish;
    end

endmodule
